// ----- design/msba_pkg.sv -----
// Shared widths, command and status codes, and the decoded command word.
package msba_pkg;

  // Field widths of the stream words
  localparam int CMD_W    = 3;
  localparam int OFF_W    = 21;
  localparam int IDX_W    = 10;
  localparam int STAT_W   = 3;
  localparam int RND_W    = OFF_W + 1;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  // Default sizing
  localparam int BUFFER_BYTES_DEF = 1048576;
  localparam int MARK_DEPTH_DEF   = 1024;

  // Allocation granule and push guard slack
  localparam int ALIGN_BYTES = 8;
  localparam int PUSH_SLACK  = 6;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_END_ALLOC = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_MARK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND      = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NO_ROOM   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd4;

  // Command word after classification, with the state-free checks done
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [RND_W-1:0] rounded;     // size rounded up to the granule
    logic [OFF_W-1:0] end_offset;  // buffer end less rounded size
    logic             size_fits;   // push guard on the raw size
    logic [RND_W-1:0] loc_top;     // location + size
    logic             loc_fits;    // location + size inside the buffer
    logic [OFF_W-1:0] location;
    logic [IDX_W-1:0] slot;
    logic             slot_fits;   // slot inside the mark stack
  } op_t;

endpackage

// ----- design/msba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module msba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/msba_front.sv -----
// Front end: takes input words, classifies them and registers the decoded command.
module msba_front import msba_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int MARK_DEPTH   = MARK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] cmd,
  input  logic [OFF_W-1:0] size,
  input  logic [OFF_W-1:0] location,
  input  logic [IDX_W-1:0] slot,
  output logic             op_valid,
  input  logic             op_ready,
  output op_t              op
);

  op_t         dec;
  logic [31:0] end_full;
  logic        hold_v;

  // Classification: everything that does not need the allocator state
  always_comb begin
    dec.cmd        = cmd;
    dec.rounded    = (RND_W'(size) + RND_W'(ALIGN_BYTES - 1)) & ~RND_W'(ALIGN_BYTES - 1);
    end_full       = 32'(BUFFER_BYTES) - 32'(dec.rounded);
    dec.end_offset = end_full[OFF_W-1:0];
    dec.size_fits  = (32'(size) + 32'(PUSH_SLACK)) < (32'(BUFFER_BYTES) - 32'd1);
    dec.loc_top    = RND_W'(location) + RND_W'(size);
    dec.loc_fits   = 32'(dec.loc_top) < 32'(BUFFER_BYTES);
    dec.location   = location;
    dec.slot       = slot;
    dec.slot_fits  = 32'(slot) < 32'(MARK_DEPTH);
  end

  // Holding register in front of the queue
  assign in_ready = !hold_v || op_ready;
  assign op_valid = hold_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (in_ready) begin
      hold_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op <= dec;
    end
  end

endmodule

// ----- design/msba_fifo.sv -----
// Short command queue that decouples the front end from the back end.
module msba_fifo import msba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  op_t  wr_op,
  output logic rd_valid,
  input  logic rd_ready,
  output op_t  rd_op
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  op_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;
  logic             push;
  logic             pop;

  assign wr_ready = fill != (PTR_W + 1)'(QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_op    = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_op;
    end
  end

endmodule

// ----- design/msba_back.sv -----
// Back end: allocator state, mark memory, command sequencing and result register.
module msba_back import msba_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int MARK_DEPTH   = MARK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_ready,
  input  op_t               op,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [OFF_W-1:0]  result_offset,
  output logic [IDX_W-1:0]  result_index
);

  localparam int CNT_W = $clog2(MARK_DEPTH);
  localparam int TOP_W = $clog2(BUFFER_BYTES);
  localparam int SUM_W = ((TOP_W > RND_W) ? TOP_W : RND_W) + 1;
  localparam int CMP_W = (TOP_W > OFF_W) ? TOP_W : OFF_W;

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_POP   = 2'd2;
  localparam logic [1:0] S_FIND  = 2'd3;

  logic [1:0]       state, state_next;
  logic [TOP_W-1:0] top, top_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] sweep, sweep_next;
  logic [CNT_W-1:0] scan, scan_next;
  logic [CNT_W-1:0] pend_idx, pend_idx_next;
  logic             pend_v, pend_v_next;
  logic [OFF_W-1:0] key, key_next;

  logic             we;
  logic [CNT_W-1:0] wa;
  logic [TOP_W-1:0] wd;
  logic [CNT_W-1:0] ra;
  logic [TOP_W-1:0] rdata;

  logic              ld;
  logic [STAT_W-1:0] ld_status;
  logic [OFF_W-1:0]  ld_offset;
  logic [IDX_W-1:0]  ld_index;

  logic             out_free;
  logic [SUM_W-1:0] top_sum;
  logic             top_room;
  logic [CNT_W:0]   cnt_inc;
  logic             stack_full;
  logic             hit;

  msba_ram #(
    .WIDTH (TOP_W),
    .DEPTH (MARK_DEPTH)
  ) u_marks (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (wa),
    .wr_data (wd),
    .rd_addr (ra),
    .rd_data (rdata)
  );

  // Checks against the current state
  assign out_free   = !out_valid || out_ready;
  assign top_sum    = SUM_W'(top) + SUM_W'(op.rounded);
  assign top_room   = top_sum < SUM_W'(BUFFER_BYTES);
  assign cnt_inc    = (CNT_W + 1)'(count) + (CNT_W + 1)'(1);
  assign stack_full = cnt_inc >= (CNT_W + 1)'(MARK_DEPTH);
  assign hit        = CMP_W'(rdata) == CMP_W'(key);

  // Sequencer
  always_comb begin
    state_next    = state;
    top_next      = top;
    count_next    = count;
    sweep_next    = sweep;
    scan_next     = scan;
    pend_idx_next = pend_idx;
    pend_v_next   = pend_v;
    key_next      = key;
    we            = 1'b0;
    wa            = count;
    wd            = '0;
    ra            = count;
    ld            = 1'b0;
    ld_status     = STAT_OK;
    ld_offset     = '0;
    ld_index      = '0;
    op_ready      = 1'b0;

    case (state)
      // zero the mark memory, one entry a cycle
      S_SWEEP: begin
        we         = 1'b1;
        wa         = sweep;
        sweep_next = sweep + CNT_W'(1);
        if (sweep == CNT_W'(MARK_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (op_valid && out_free) begin
          op_ready = 1'b1;
          case (op.cmd)
            CMD_CLEAR: begin
              top_next   = '0;
              count_next = '0;
              sweep_next = '0;
              state_next = S_SWEEP;
              ld         = 1'b1;
            end
            CMD_PUSH: begin
              ld = 1'b1;
              if (stack_full) begin
                ld_status = STAT_FULL;
              end else if (!op.size_fits || !top_room) begin
                ld_status = STAT_NO_ROOM;
              end else begin
                we         = 1'b1;
                wa         = CNT_W'(cnt_inc);
                wd         = top;
                count_next = CNT_W'(cnt_inc);
                top_next   = TOP_W'(top_sum);
                ld_offset  = OFF_W'(top);
              end
            end
            CMD_POP: begin
              // read of the latest mark goes out this cycle
              if (count == '0) begin
                ld        = 1'b1;
                ld_status = STAT_EMPTY;
              end else begin
                state_next = S_POP;
              end
            end
            CMD_END_ALLOC: begin
              ld = 1'b1;
              if (top_room) begin
                ld_offset = op.end_offset;
              end else begin
                ld_status = STAT_NO_ROOM;
              end
            end
            CMD_SET_MARK: begin
              ld = 1'b1;
              if (!op.slot_fits) begin
                ld_status = STAT_FULL;
              end else if (op.loc_fits) begin
                we         = 1'b1;
                wa         = CNT_W'(op.slot);
                wd         = TOP_W'(op.location);
                count_next = CNT_W'(op.slot);
                top_next   = TOP_W'(op.loc_top);
              end else begin
                ld_status = STAT_NO_ROOM;
              end
            end
            CMD_FIND: begin
              if (count == '0) begin
                ld        = 1'b1;
                ld_status = STAT_NOT_FOUND;
              end else begin
                key_next    = op.location;
                scan_next   = CNT_W'(1);
                pend_v_next = 1'b0;
                state_next  = S_FIND;
              end
            end
            default: begin
              ld = 1'b1;
            end
          endcase
        end
      end

      // restore top from the mark read last cycle and clear that mark
      S_POP: begin
        we         = 1'b1;
        wa         = count;
        top_next   = rdata;
        count_next = count - CNT_W'(1);
        ld         = 1'b1;
        ld_offset  = OFF_W'(rdata);
        state_next = S_IDLE;
      end

      // one read per cycle, each compared in the cycle after its read
      S_FIND: begin
        ra            = scan;
        scan_next     = scan + CNT_W'(1);
        pend_idx_next = scan;
        pend_v_next   = 1'b1;
        if (pend_v && hit) begin
          ld         = 1'b1;
          ld_index   = IDX_W'(pend_idx);
          state_next = S_IDLE;
        end else if (pend_v && pend_idx == count) begin
          ld         = 1'b1;
          ld_status  = STAT_NOT_FOUND;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_SWEEP;
      top    <= '0;
      count  <= '0;
      sweep  <= '0;
      pend_v <= 1'b0;
    end else begin
      state  <= state_next;
      top    <= top_next;
      count  <= count_next;
      sweep  <= sweep_next;
      pend_v <= pend_v_next;
    end
  end

  always_ff @(posedge clk) begin
    scan     <= scan_next;
    pend_idx <= pend_idx_next;
    key      <= key_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      status        <= ld_status;
      result_offset <= ld_offset;
      result_index  <= ld_index;
    end
  end

endmodule

// ----- design/mark_stack_bump_allocator_unit.sv -----
// Bump allocator with a mark stack: one result word per command word.
// Latency and rate are set by the single port pair of the mark memory. After reset
// and after every clear command the mark memory is zeroed, one entry a cycle,
// during which no command is executed (the input queue still fills). Once running,
// clear, push, end_alloc, set_mark and the unused codes finish in the back end's
// idle state; pop reads the latest mark, then restores top and clears the mark (on
// an empty stack it only reports empty), and find reads the marks from index 1
// upwards, one per cycle, until a hit or the top mark (on an empty stack it only
// reports not found). Front end and a two-entry queue add registers but no rate
// cost, so with a ready sink simple commands sustain one word a cycle.
module mark_stack_bump_allocator_unit import msba_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int MARK_DEPTH   = MARK_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // size, location, slot, zero pad
  input  logic [CMD_W-1:0]      s_tuser,  // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // result_offset, result_index, zero pad
  output logic [STAT_W-1:0]     m_tuser   // status
);

  logic              f_valid;
  logic              f_ready;
  op_t               f_op;
  logic              q_valid;
  logic              q_ready;
  op_t               q_op;
  logic [OFF_W-1:0]  result_offset;
  logic [IDX_W-1:0]  result_index;

  msba_front #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MARK_DEPTH   (MARK_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (s_tuser),
    .size     (s_tdata[OFF_W-1:0]),
    .location (s_tdata[2*OFF_W-1:OFF_W]),
    .slot     (s_tdata[2*OFF_W+IDX_W-1:2*OFF_W]),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op       (f_op)
  );

  msba_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_op    (f_op),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_op    (q_op)
  );

  msba_back #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MARK_DEPTH   (MARK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .op_valid      (q_valid),
    .op_ready      (q_ready),
    .op            (q_op),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .status        (m_tuser),
    .result_offset (result_offset),
    .result_index  (result_index)
  );

  // Result word packing
  assign m_tdata = {(OUT_DATA_W - OFF_W - IDX_W)'(0), result_index, result_offset};

endmodule
